// ===== src/booth_pkg.sv =====
// ----------------------------------------------------------------------------
// booth_pkg
// Shared types and constants for the radix-2 Booth multiplier: controller
// states, the command group from controller to datapath and Booth pair codes.
// ----------------------------------------------------------------------------
`default_nettype none

package booth_pkg;

    // controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } booth_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // take new operands, clear accumulator
        logic step;     // one Booth add/subtract and arithmetic shift
        logic capture;  // move finished product into the output register
    } booth_cmd_t;

    // Booth recoding of {current multiplier bit, previous bit}
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

endpackage

`default_nettype wire

// ===== src/booth_radix2_multiplier_core.sv =====
// ----------------------------------------------------------------------------
// booth_radix2_multiplier_core
// Signed WIDTH x WIDTH radix-2 Booth multiplier with valid/stall handshakes.
// ----------------------------------------------------------------------------
// Multiplies two signed two's-complement operands of WIDTH bits and returns
// the full signed product of 2*WIDTH bits, exact for every operand pair
// including most-negative times most-negative. Each transaction runs WIDTH
// Booth add/subtract-and-shift iterations through one shared adder and then
// hands the product to the output register. When the output register is
// free, that hand-over also takes in the next operands, so back-to-back
// transactions follow without an idle state between them. A product waiting
// in the output register does not hold off the next transaction's
// iterations; only its hand-over, and with it the acceptance of further
// operands, waits until the output side takes the waiting product.
`default_nettype none

module booth_radix2_multiplier_core #(
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [WIDTH-1:0]  multiplicand,
    input  wire logic signed [WIDTH-1:0]  multiplier,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [2*WIDTH-1:0]     product
);
    import booth_pkg::*;

    booth_cmd_t cmd;

    // sequencing and handshakes
    booth_controller #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // accumulator, shared adder and product register
    booth_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .product      (product)
    );

endmodule

`default_nettype wire

// ===== src/booth_datapath.sv =====
// ----------------------------------------------------------------------------
// booth_datapath
// Accumulator, multiplier shift register, previous-bit flop and the single
// shared adder/subtractor, plus the output product register.
// ----------------------------------------------------------------------------
`default_nettype none

module booth_datapath #(
    parameter int WIDTH = 8
) (
    input  wire logic                      clk,
    input  wire booth_pkg::booth_cmd_t     cmd,
    input  wire logic signed [WIDTH-1:0]   multiplicand,
    input  wire logic signed [WIDTH-1:0]   multiplier,
    output logic signed [2*WIDTH-1:0]      product
);
    import booth_pkg::*;

    // accumulator and multiplicand carry one guard bit
    logic [WIDTH:0]       acc_reg,  acc_next;
    logic [WIDTH:0]       m_reg,    m_next;
    logic [WIDTH-1:0]     q_reg,    q_next;
    logic                 prev_reg, prev_next;
    logic [2*WIDTH-1:0]   product_reg, product_next;
    logic [WIDTH:0]       sum;

    // booth add, subtract or pass
    always_comb
    begin
        unique case ({q_reg[0], prev_reg})
            BOOTH_ADD: sum = acc_reg + m_reg;
            BOOTH_SUB: sum = acc_reg - m_reg;
            default:   sum = acc_reg;
        endcase
    end

    // next-state of the working registers
    always_comb
    begin
        acc_next     = acc_reg;
        m_next       = m_reg;
        q_next       = q_reg;
        prev_next    = prev_reg;
        product_next = product_reg;
        if (cmd.load)
        begin
            acc_next  = '0;
            m_next    = {multiplicand[WIDTH-1], multiplicand};
            q_next    = multiplier;
            prev_next = 1'b0;
        end
        else if (cmd.step)
        begin
            // arithmetic right shift of the acc, q, prev chain
            acc_next  = {sum[WIDTH], sum[WIDTH:1]};
            q_next    = {sum[0], q_reg[WIDTH-1:1]};
            prev_next = q_reg[0];
        end
        if (cmd.capture)
        begin
            product_next = {acc_reg[WIDTH-1:0], q_reg};
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        m_reg       <= m_next;
        q_reg       <= q_next;
        prev_reg    <= prev_next;
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// ===== src/booth_controller.sv =====
// ----------------------------------------------------------------------------
// booth_controller
// State machine that sequences load, WIDTH Booth steps and the hand-over of
// the product, and runs both transaction handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module booth_controller #(
    parameter int WIDTH = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output booth_pkg::booth_cmd_t      cmd
);
    import booth_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    booth_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;
    logic             in_take;
    logic             last_step;

    // output register can take a product this cycle
    assign slot_free = !out_valid_reg || !out_stall;
    assign last_step = (cnt_reg == CNT_W'(WIDTH - 1));

    // input accepted when idle, or while handing over the previous product
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_HOLD: in_stall = !slot_free;
            default: in_stall = 1'b1;
        endcase
    end

    assign in_take = in_valid && !in_stall;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    if (in_take)
                    begin
                        cmd.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== test/booth_radix2_multiplier_checker.sv =====
// ----------------------------------------------------------------------------
// booth_radix2_multiplier_checker
// Watches both channels of the Booth multiplier, works out the product of
// every accepted operand pair by its own Booth recoding and compares each
// accepted product, in order, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module booth_radix2_multiplier_checker
    import booth_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [WIDTH-1:0]  multiplicand,
    input  logic signed [WIDTH-1:0]  multiplier,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [2*WIDTH-1:0] product,
    output int                       errors,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [2*WIDTH-1:0] expected_products [$];
    logic signed [2*WIDTH-1:0] want;

    // radix-2 booth: scan multiplier pairs, add/subtract, arithmetic shift
    function automatic logic signed [2*WIDTH-1:0] booth_product(
        input logic signed [WIDTH-1:0] mcand,
        input logic [WIDTH-1:0]        mplier
    );
        logic signed [WIDTH+1:0] acc;
        logic signed [WIDTH+1:0] mcand_ext;
        logic [WIDTH-1:0]        q;
        logic                    prev;
        acc       = '0;
        mcand_ext = {{2{mcand[WIDTH-1]}}, mcand};
        q         = mplier;
        prev      = 1'b0;
        for (int i = 0; i < WIDTH; i++)
        begin
            case ({q[0], prev})
                BOOTH_SUB: acc = acc - mcand_ext;
                BOOTH_ADD: acc = acc + mcand_ext;
                default:   ;
            endcase
            prev = q[0];
            q    = {acc[0], q[WIDTH-1:1]};
            acc  = acc >>> 1;
        end
        return {acc[WIDTH-1:0], q};
    endfunction

    // compare accepted products, then record newly accepted operands
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            expected_products.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_products.size() == 0)
                begin
                    $error("product: expected no transaction, actual %0d", product);
                    errors++;
                end
                else
                begin
                    want = expected_products.pop_front();
                    if (product !== want)
                    begin
                        $error("product: expected %0d, actual %0d", want, product);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_products.push_back(booth_product(multiplicand, multiplier));
            pending = expected_products.size();
        end
    end

endmodule

// ===== test/booth_radix2_multiplier_core_test.sv =====
// ----------------------------------------------------------------------------
// booth_radix2_multiplier_core_test
// Drives operand pairs into the Booth multiplier (directed corners, then
// random pairs biased towards extremes) with random idling on both sides,
// a long output hold-off and a full drain, and reports the checker verdict.
// ----------------------------------------------------------------------------

module booth_radix2_multiplier_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH           = 8;
    localparam int RANDOM_ITEMS    = 1950;
    localparam int IDLE_PCT        = 29;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic [WIDTH-1:0] ONE      = WIDTH'(1);
    localparam logic [WIDTH-1:0] ALL_ONES = '1;

    // directed corners: extremes, signs, alternating booth pairs
    localparam logic [WIDTH-1:0] DIRECTED_A [18] = '{
        '0, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, ALL_ONES, ONE, ALL_ONES,
        MOST_NEG, ONE, '0, MOST_NEG, MOST_POS, MOST_NEG, 8'h5a, 8'ha5,
        8'h33, MOST_POS
    };
    localparam logic [WIDTH-1:0] DIRECTED_B [18] = '{
        '0, MOST_NEG, MOST_POS, MOST_POS, MOST_NEG, ALL_ONES, ALL_ONES, ONE,
        ONE, MOST_NEG, MOST_NEG, '0, 8'h55, 8'haa, ALL_ONES, ONE,
        8'hcc, MOST_NEG
    };

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [WIDTH-1:0]  multiplicand = '0;
    logic signed [WIDTH-1:0]  multiplier = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [2*WIDTH-1:0] product;
    int                       errors;
    int                       pending;
    bit                       idle_on = 1'b1;
    int                       hold_cycles = 0;

    booth_radix2_multiplier_core #(
        .WIDTH(WIDTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .product      (product)
    );

    booth_radix2_multiplier_checker #(
        .WIDTH(WIDTH)
    ) product_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .product      (product),
        .errors       (errors),
        .pending      (pending)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // operand biased towards extremes, zero, minus one and small values
    function automatic logic [WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return $urandom_range(0, 1) ? ALL_ONES : '0;
            3:       return WIDTH'($urandom_range(0, 3));
            default: return WIDTH'($urandom());
        endcase
    endfunction

    // one operand transaction; entered and left at a falling edge
    task automatic send_operands(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b);
        while (idle_on && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        multiplicand <= a;
        multiplier   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender pause until every product has come out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // output side: random stall, or a counted hold-off when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(DIRECTED_A); i++)
            send_operands(DIRECTED_A[i], DIRECTED_B[i]);
        wait_for_drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // stretch with no idling on either side
            if (i == 300)
                idle_on = 1'b0;
            if (i == 700)
                idle_on = 1'b1;
            // long output hold-off while operands keep coming
            if (i == 1000)
                hold_cycles = HOLD_OFF_CYCLES;
            if (i == 1300)
                wait_for_drain();
            send_operands(pick_operand(), pick_operand());
        end

        wait_for_drain();
        repeat (4 * (WIDTH + 1)) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/booth_pkg.sv
src/booth_datapath.sv
src/booth_controller.sv
src/booth_radix2_multiplier_core.sv
test/booth_radix2_multiplier_checker.sv
test/booth_radix2_multiplier_core_test.sv
